>>> hw/rtl/ldd_pkg.sv
package ldd_pkg;

    localparam int MAX_WIDTH_DEF      = 2048;
    localparam int PIXEL_BITS_DEF     = 16;
    localparam int PIXEL_PORT_BITS    = 16;
    localparam int ROW_WIDTH_BITS     = 12;
    localparam int FIELD_HEIGHT_BITS  = 13;
    localparam int ROW_BITS           = 12;
    localparam int HEIGHT_LIMIT       = 4096;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 13;

    localparam logic [ROW_WIDTH_BITS-1:0]    RESET_ROW_WIDTH    = 12'd2048;
    localparam logic [FIELD_HEIGHT_BITS-1:0] RESET_FIELD_HEIGHT = 13'd1024;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_HEIGHT = 2'd1;

    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_BITS   = 2;
    localparam int QUEUE_LEVEL_BITS = 3;

    typedef struct packed {
        logic                        not_empty;
        logic [QUEUE_LEVEL_BITS-1:0] level;
    } q_status_t;

endpackage

>>> hw/rtl/ldd_ram.sv
module ldd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a shared address
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

>>> hw/rtl/ldd_front.sv
module ldd_front #(
    parameter int MAX_WIDTH  = ldd_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = ldd_pkg::PIXEL_BITS_DEF,
    parameter int COLW       = $clog2(MAX_WIDTH),
    parameter int ITEM_W     = COLW + ldd_pkg::ROW_BITS + 2 * PIXEL_BITS + 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [ldd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ldd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ldd_pkg::PIXEL_PORT_BITS-1:0] pixel,
    input  ldd_pkg::q_status_t                  q_status,
    output logic                                push,
    output logic [ITEM_W-1:0]                   push_item
);

    localparam int RB   = ldd_pkg::ROW_BITS;
    localparam int RWB  = ldd_pkg::ROW_WIDTH_BITS;
    localparam int FHB  = ldd_pkg::FIELD_HEIGHT_BITS;
    localparam int WCMP = (RWB > COLW + 1) ? RWB : COLW + 1;
    localparam int LB   = ldd_pkg::QUEUE_LEVEL_BITS + 1;

    logic [RWB-1:0]        row_width_reg;
    logic [FHB-1:0]        field_height_reg;
    logic [COLW-1:0]       col_reg, col_next;
    logic [RB-1:0]         row_reg, row_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic [COLW-1:0]       s1_col_reg;
    logic [RB-1:0]         s1_row_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  s1_blend_reg, s1_edge_reg, s1_fe_reg;

    logic [WCMP-1:0]       rw_ext, max_w, w_eff, col_ext, col_cur_ext;
    logic [FHB-1:0]        h_eff, row_ext;
    logic [COLW-1:0]       col_cur;
    logic                  last_col, last_row, accept;
    logic [PIXEL_BITS-1:0] pix, prev;
    logic [LB-1:0]         occupancy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= ldd_pkg::RESET_ROW_WIDTH;
            field_height_reg <= ldd_pkg::RESET_FIELD_HEIGHT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ldd_pkg::REG_ROW_WIDTH:    row_width_reg    <= cfg_data[RWB-1:0];
                ldd_pkg::REG_FIELD_HEIGHT: field_height_reg <= cfg_data[FHB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rw_ext = WCMP'(row_width_reg);
        max_w  = WCMP'(MAX_WIDTH);
        if (rw_ext == '0)
        begin
            w_eff = WCMP'(1);
        end
        else if (rw_ext > max_w)
        begin
            w_eff = max_w;
        end
        else
        begin
            w_eff = rw_ext;
        end

        if (field_height_reg == '0)
        begin
            h_eff = FHB'(1);
        end
        else if (field_height_reg > FHB'(ldd_pkg::HEIGHT_LIMIT))
        begin
            h_eff = FHB'(ldd_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = field_height_reg;
        end

        col_ext     = WCMP'(col_reg);
        col_cur_ext = (col_ext >= w_eff) ? w_eff - WCMP'(1) : col_ext;
        col_cur     = col_cur_ext[COLW-1:0];
        last_col    = (col_cur_ext + WCMP'(1)) >= w_eff;
        row_ext     = FHB'(row_reg);
        last_row    = (row_ext + FHB'(1)) >= h_eff;

        occupancy = LB'(q_status.level) + LB'(s1_valid_reg);
        in_stall  = occupancy >= LB'(ldd_pkg::QUEUE_DEPTH);
        accept    = in_valid && !in_stall;
        pix       = pixel[PIXEL_BITS-1:0];

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RB'(1);
            end
            else
            begin
                col_next = col_cur + COLW'(1);
            end
        end
        s1_valid_next = accept && ((row_reg != '0) || last_row);
    end

    ldd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_cur),
        .wdata (pix),
        .re    (accept),
        .raddr (col_cur),
        .rdata (prev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_cur;
            s1_row_reg   <= row_reg;
            s1_pix_reg   <= pix;
            s1_blend_reg <= row_reg != '0;
            s1_edge_reg  <= last_row;
            s1_fe_reg    <= last_row && last_col;
        end
    end

    assign push      = s1_valid_reg;
    assign push_item = {s1_col_reg, s1_row_reg, prev, s1_pix_reg,
                        s1_blend_reg, s1_edge_reg, s1_fe_reg};

endmodule

>>> hw/rtl/ldd_fifo.sv
module ldd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   head_data,
    output ldd_pkg::q_status_t status
);

    localparam int PB = ldd_pkg::QUEUE_PTR_BITS;
    localparam int LB = ldd_pkg::QUEUE_LEVEL_BITS;

    logic [WIDTH-1:0] store [ldd_pkg::QUEUE_DEPTH];
    logic [PB-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LB-1:0]    level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PB'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PB'(1) : rd_ptr_reg;
        level_next  = level_reg + LB'(push) - LB'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data        = store[rd_ptr_reg];
    assign status.not_empty = level_reg != '0;
    assign status.level     = level_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg < LB'(ldd_pkg::QUEUE_DEPTH)) || pop)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level_reg != '0)
        else $error("queue popped while empty");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LB'(ldd_pkg::QUEUE_DEPTH))
        else $error("queue level out of range");
`endif

endmodule

>>> hw/rtl/ldd_back.sv
module ldd_back #(
    parameter int PIXEL_BITS = ldd_pkg::PIXEL_BITS_DEF,
    parameter int COLW       = 11,
    parameter int ITEM_W     = COLW + ldd_pkg::ROW_BITS + 2 * PIXEL_BITS + 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ldd_pkg::q_status_t                  q_status,
    input  logic [ITEM_W-1:0]                   head_item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COLW-1:0]                     column,
    output logic [ldd_pkg::ROW_BITS-1:0]        pair_row,
    output logic [ldd_pkg::PIXEL_PORT_BITS-1:0] copy_pixel,
    output logic [ldd_pkg::PIXEL_PORT_BITS-1:0] blend_pixel,
    output logic                                frame_end,
    output logic                                last
);

    localparam int RB = ldd_pkg::ROW_BITS;
    localparam int PP = ldd_pkg::PIXEL_PORT_BITS;

    logic [COLW-1:0]       h_col;
    logic [RB-1:0]         h_row;
    logic [PIXEL_BITS-1:0] h_prev, h_pix;
    logic                  h_blend, h_edge, h_fe;
    logic [PIXEL_BITS:0]   sum;

    logic                  phase_reg, phase_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  load, emit_edge;

    logic [COLW-1:0]       col_reg;
    logic [RB-1:0]         row_reg;
    logic [PP-1:0]         copy_reg, blend_reg;
    logic                  fe_reg, last_reg;

    always_comb
    begin
        {h_col, h_row, h_prev, h_pix, h_blend, h_edge, h_fe} = head_item;
        sum       = {1'b0, h_prev} + {1'b0, h_pix};
        emit_edge = !h_blend || phase_reg;
        load      = q_status.not_empty && (!out_valid_reg || !out_stall);
        pop       = load && (emit_edge || !h_edge);

        phase_next = phase_reg;
        if (load)
        begin
            phase_next = !emit_edge && h_edge;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg <= h_col;
            if (emit_edge)
            begin
                row_reg   <= h_row;
                copy_reg  <= PP'(h_pix);
                blend_reg <= PP'(h_pix);
                fe_reg    <= h_fe;
                last_reg  <= 1'b1;
            end
            else
            begin
                row_reg   <= h_row - RB'(1);
                copy_reg  <= PP'(h_prev);
                blend_reg <= PP'(sum[PIXEL_BITS:1]);
                fe_reg    <= 1'b0;
                last_reg  <= !h_edge;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign column      = col_reg;
    assign pair_row    = row_reg;
    assign copy_pixel  = copy_reg;
    assign blend_pixel = blend_reg;
    assign frame_end   = fe_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_phase_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> q_status.not_empty && h_blend && h_edge)
        else $error("second result pending without a queued transaction");

    a_frame_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fe_reg |-> last_reg)
        else $error("frame end on a non-final result");

    a_blend_then_edge: assert property (@(posedge clk) disable iff (!rst_n)
        load && !emit_edge && h_edge |=> phase_reg)
        else $error("edge pair skipped after blended pair");
`endif

endmodule

>>> hw/rtl/line_doubling_deinterlacer_core.sv
// channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_stall   | pixel
// out     | out       | out_valid/out_stall | column, pair_row, copy_pixel,
//         |           |                     | blend_pixel, frame_end, last
//
// one pixel per cycle while in_stall is low; the output is registered
// last row past row 0 gives two results per pixel; output then sets the pace
// a four entry queue parts the line store stage from the output register
// reset clears counters, queue and output valid; line store is not cleared
// cfg_ready is always high; writes only while idle
module line_doubling_deinterlacer_core #(
    parameter int MAX_WIDTH  = ldd_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = ldd_pkg::PIXEL_BITS_DEF,
    parameter int COLW       = $clog2(MAX_WIDTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ldd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ldd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ldd_pkg::PIXEL_PORT_BITS-1:0] pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COLW-1:0]                     column,
    output logic [ldd_pkg::ROW_BITS-1:0]        pair_row,
    output logic [ldd_pkg::PIXEL_PORT_BITS-1:0] copy_pixel,
    output logic [ldd_pkg::PIXEL_PORT_BITS-1:0] blend_pixel,
    output logic                                frame_end,
    output logic                                last
);

    localparam int ITEM_W = COLW + ldd_pkg::ROW_BITS + 2 * PIXEL_BITS + 3;

    ldd_pkg::q_status_t q_status;
    logic               push, pop;
    logic [ITEM_W-1:0]  push_item, head_item;

    assign cfg_ready = 1'b1;

    ldd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .COLW       (COLW),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    ldd_fifo #(
        .WIDTH (ITEM_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .pop       (pop),
        .head_data (head_item),
        .status    (q_status)
    );

    ldd_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .COLW       (COLW),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .column      (column),
        .pair_row    (pair_row),
        .copy_pixel  (copy_pixel),
        .blend_pixel (blend_pixel),
        .frame_end   (frame_end),
        .last        (last)
    );

endmodule

>>> tb/deinterlace_checker.sv
module deinterlace_checker (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           cfg_valid,
    input  logic                                           cfg_ready,
    input  logic [ldd_pkg::CFG_INDEX_BITS-1:0]             cfg_index,
    input  logic [ldd_pkg::CFG_DATA_BITS-1:0]              cfg_data,
    input  logic                                           in_valid,
    input  logic                                           in_stall,
    input  logic [ldd_pkg::PIXEL_PORT_BITS-1:0]            pixel,
    input  logic                                           out_valid,
    input  logic                                           out_stall,
    input  logic [$clog2(ldd_pkg::MAX_WIDTH_DEF)-1:0]      column,
    input  logic [ldd_pkg::ROW_BITS-1:0]                   pair_row,
    input  logic [ldd_pkg::PIXEL_PORT_BITS-1:0]            copy_pixel,
    input  logic [ldd_pkg::PIXEL_PORT_BITS-1:0]            blend_pixel,
    input  logic                                           frame_end,
    input  logic                                           last,
    output int                                             failures,
    output int                                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import ldd_pkg::*;

    localparam int COL_BITS       = $clog2(MAX_WIDTH_DEF);
    localparam int MISMATCH_SHOWN = 10;

    typedef struct packed {
        logic [COL_BITS-1:0]        column;
        logic [ROW_BITS-1:0]        pair_row;
        logic [PIXEL_PORT_BITS-1:0] copy_pixel;
        logic [PIXEL_PORT_BITS-1:0] blend_pixel;
        logic                       frame_end;
        logic                       last;
    } pair_result_t;

    logic [PIXEL_PORT_BITS-1:0]   line_mem [0:MAX_WIDTH_DEF-1];
    logic [COL_BITS-1:0]          col_pos;
    logic [ROW_BITS-1:0]          row_pos;
    logic [ROW_WIDTH_BITS-1:0]    width_reg;
    logic [FIELD_HEIGHT_BITS-1:0] height_reg;
    pair_result_t                 expected_pairs [$];
    int                           mismatch_total;

    function automatic string pair_text(pair_result_t p);
        return $sformatf("col %0d row %0d copy %h blend %h frame_end %b last %b",
                         p.column, p.pair_row, p.copy_pixel, p.blend_pixel,
                         p.frame_end, p.last);
    endfunction

    // pairs caused by one accepted pixel, then the store and counters move on
    task automatic predict_pairs(input logic [PIXEL_PORT_BITS-1:0] px);
        int           w;
        int           h;
        int           c;
        bit           last_col;
        bit           last_row;
        logic [16:0]  total;
        pair_result_t res;
        w = (width_reg == 0) ? 1 :
            (int'(width_reg) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
        h = (height_reg == 0) ? 1 :
            (int'(height_reg) > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg);
        c = (int'(col_pos) >= w) ? w - 1 : int'(col_pos);
        last_col = (c + 1 >= w);
        last_row = (int'(row_pos) + 1 >= h);
        if (row_pos != 0)
        begin
            total           = {1'b0, line_mem[c]} + {1'b0, px};
            res.column      = c[COL_BITS-1:0];
            res.pair_row    = row_pos - ROW_BITS'(1);
            res.copy_pixel  = line_mem[c];
            res.blend_pixel = total[16:1];
            res.frame_end   = 1'b0;
            res.last        = !last_row;
            expected_pairs.push_back(res);
        end
        if (last_row)
        begin
            res.column      = c[COL_BITS-1:0];
            res.pair_row    = row_pos;
            res.copy_pixel  = px;
            res.blend_pixel = px;
            res.frame_end   = last_col;
            res.last        = 1'b1;
            expected_pairs.push_back(res);
        end
        line_mem[c] = px;
        if (last_col)
        begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + ROW_BITS'(1);
        end
        else
        begin
            col_pos = COL_BITS'(c + 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        pair_result_t seen;
        pair_result_t want;
        if (!rst_n)
        begin
            expected_pairs.delete();
            col_pos        = '0;
            row_pos        = '0;
            width_reg      = RESET_ROW_WIDTH;
            height_reg     = RESET_FIELD_HEIGHT;
            mismatch_total = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROW_WIDTH:    width_reg  = cfg_data[ROW_WIDTH_BITS-1:0];
                    REG_FIELD_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            // results are compared before this edge's pixel adds its own
            if (out_valid && !out_stall)
            begin
                seen.column      = column;
                seen.pair_row    = pair_row;
                seen.copy_pixel  = copy_pixel;
                seen.blend_pixel = blend_pixel;
                seen.frame_end   = frame_end;
                seen.last        = last;
                if (expected_pairs.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= MISMATCH_SHOWN)
                        $display("%t unexpected pair: %s", $realtime, pair_text(seen));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (seen !== want)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= MISMATCH_SHOWN)
                            $display("%t pair mismatch: expected %s, got %s",
                                     $realtime, pair_text(want), pair_text(seen));
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_pairs(pixel);
        end
        failures    <= mismatch_total;
        outstanding <= expected_pairs.size();
    end

endmodule

>>> tb/line_doubling_deinterlacer_core_tb.sv
module line_doubling_deinterlacer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ldd_pkg::*;

    localparam int COL_BITS       = $clog2(MAX_WIDTH_DEF);
    localparam int ITEM_TARGET    = 1976;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} stall_mode_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    cfg_index;
    logic [CFG_DATA_BITS-1:0]     cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [PIXEL_PORT_BITS-1:0]   pixel;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [COL_BITS-1:0]          column;
    logic [ROW_BITS-1:0]          pair_row;
    logic [PIXEL_PORT_BITS-1:0]   copy_pixel;
    logic [PIXEL_PORT_BITS-1:0]   blend_pixel;
    logic                         frame_end;
    logic                         last;

    int failures;
    int outstanding;

    // where the stream stands, kept so that a wider row never reads an empty column
    logic [ROW_WIDTH_BITS-1:0]    wid_raw = RESET_ROW_WIDTH;
    logic [FIELD_HEIGHT_BITS-1:0] hgt_raw = RESET_FIELD_HEIGHT;
    int                           at_col = 0;
    int                           at_row = 0;
    bit                           col_written [0:MAX_WIDTH_DEF-1];
    int                           items_sent = 0;
    int                           burst_left = 0;

    stall_mode_t                  stall_mode = STALL_NONE;
    int                           stall_left = 0;
    int                           quiet_cycles = 0;

    always #5ns clk = ~clk;

    line_doubling_deinterlacer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .column      (column),
        .pair_row    (pair_row),
        .copy_pixel  (copy_pixel),
        .blend_pixel (blend_pixel),
        .frame_end   (frame_end),
        .last        (last)
    );

    deinterlace_checker pair_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .column      (column),
        .pair_row    (pair_row),
        .copy_pixel  (copy_pixel),
        .blend_pixel (blend_pixel),
        .frame_end   (frame_end),
        .last        (last),
        .failures    (failures),
        .outstanding (outstanding)
    );

    function automatic int width_of(logic [ROW_WIDTH_BITS-1:0] raw);
        if (raw == 0)
            return 1;
        if (int'(raw) > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return int'(raw);
    endfunction

    function automatic int height_of(logic [FIELD_HEIGHT_BITS-1:0] raw);
        if (raw == 0)
            return 1;
        if (int'(raw) > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return int'(raw);
    endfunction

    function automatic bit width_fits(logic [ROW_WIDTH_BITS-1:0] raw);
        int w;
        w = width_of(raw);
        if (w <= width_of(wid_raw) || at_row == 0)
            return 1'b1;
        for (int i = 0; i < w; i++)
            if (!col_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [PIXEL_PORT_BITS-1:0] pick_pixel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return PIXEL_PORT_BITS'($urandom);
    endfunction

    task automatic cfg_beat(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input bit set_w, input logic [CFG_DATA_BITS-1:0] w_data,
                                input bit set_h, input logic [CFG_DATA_BITS-1:0] h_data,
                                input bit set_spare);
        if (set_w)
        begin
            cfg_beat(REG_ROW_WIDTH, w_data);
            wid_raw = w_data[ROW_WIDTH_BITS-1:0];
        end
        if (set_h)
        begin
            cfg_beat(REG_FIELD_HEIGHT, h_data);
            hgt_raw = h_data;
        end
        if (set_spare)
            cfg_beat(REG_SPARE, CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one input transaction; returns at the edge that accepts it
    task automatic send_pixel(input logic [PIXEL_PORT_BITS-1:0] value);
        int w;
        int h;
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        w = width_of(wid_raw);
        h = height_of(hgt_raw);
        if (at_col >= w)
            at_col = w - 1;
        col_written[at_col] = 1'b1;
        if (at_col + 1 >= w)
        begin
            at_col = 0;
            at_row = (at_row + 1 >= h) ? 0 : at_row + 1;
        end
        else
        begin
            at_col++;
        end
        items_sent++;
    endtask

    task automatic feed_pixels(input int count, input bit steady);
        int gap;
        for (int i = 0; i < count; i++)
        begin
            if (!steady && burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            if (burst_left > 0)
                burst_left--;
            send_pixel(pick_pixel());
        end
    endtask

    // hold the sender until every pair is out and the pipeline has emptied
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(50, 300);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            STALL_WAVE:  out_stall <= stall_left[2];
            default:     out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("line_doubling_deinterlacer_core_tb: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [ROW_WIDTH_BITS-1:0]    w_pick;
        logic [FIELD_HEIGHT_BITS-1:0] h_pick;
        logic [CFG_DATA_BITS-1:0]     w_data;
        int                           choice;
        int                           which;
        int                           count;
        int                           fld;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel     = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first row at reset geometry: stored only
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h0001);
        drain();

        // one-row field set mid-row: edge pairs straight away
        program_regs(1'b0, '0, 1'b1, 13'd1, 1'b0);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFE);
        drain();

        // narrower row mid-row, column clamps to the last one
        program_regs(1'b1, 13'd3, 1'b1, 13'd2, 1'b0);
        send_pixel(16'hAAAA);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);
        drain();

        // zero width and height count as one
        program_regs(1'b1, 13'd0, 1'b1, 13'd0, 1'b0);
        send_pixel(16'h1234);
        send_pixel(16'hEDCB);
        drain();

        // oversized registers saturate
        program_regs(1'b1, 13'd4095, 1'b1, 13'd8191, 1'b1);
        send_pixel(16'h00FF);
        send_pixel(16'hFF00);
        send_pixel(16'h0F0F);
        drain();

        program_regs(1'b1, 13'd2, 1'b1, 13'd3, 1'b0);
        send_pixel(16'hF0F0);
        send_pixel(16'h3C3C);
        send_pixel(16'hC3C3);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        drain();

        // tallest field, then cut short so the current row is past the end
        program_regs(1'b1, 13'd1, 1'b1, 13'd4096, 1'b0);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8001);
        send_pixel(16'h7FFE);
        drain();
        program_regs(1'b0, '0, 1'b1, 13'd2, 1'b0);
        send_pixel(16'hFFFF);

        while (items_sent < ITEM_TARGET)
        begin
            drain();
            choice = $urandom_range(0, 9);
            if (choice < 6)
                w_pick = ROW_WIDTH_BITS'($urandom_range(1, 12));
            else if (choice < 8)
                w_pick = ROW_WIDTH_BITS'($urandom_range(13, 80));
            else if (choice == 8)
                w_pick = ROW_WIDTH_BITS'(($urandom_range(0, 1) != 0) ?
                                         0 : $urandom_range(2048, 4095));
            else
                w_pick = ROW_WIDTH_BITS'($urandom_range(1, 2048));
            if (!width_fits(w_pick))
                w_pick = ROW_WIDTH_BITS'($urandom_range(1, width_of(wid_raw)));
            choice = $urandom_range(0, 9);
            if (choice < 6)
                h_pick = FIELD_HEIGHT_BITS'($urandom_range(1, 6));
            else if (choice < 8)
                h_pick = FIELD_HEIGHT_BITS'($urandom_range(7, 40));
            else if (choice == 8)
                h_pick = FIELD_HEIGHT_BITS'(($urandom_range(0, 1) != 0) ?
                                            0 : $urandom_range(4096, 8191));
            else
                h_pick = FIELD_HEIGHT_BITS'($urandom_range(1, 4096));
            w_data     = '0;
            w_data[ROW_WIDTH_BITS-1:0] = w_pick;
            w_data[CFG_DATA_BITS-1]    = 1'($urandom_range(0, 1));
            which = $urandom_range(0, 3);
            program_regs(which != 2, w_data, which != 1, h_pick, which == 3);
            fld = width_of(wid_raw) * height_of(hgt_raw);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, 30);
            else if (fld <= 80)
                count = fld * $urandom_range(1, 2);
            else
                count = $urandom_range(20, 150);
            feed_pixels(count, $urandom_range(0, 4) == 0);
        end
        drain();

        if (failures == 0 && outstanding == 0)
            $display("line_doubling_deinterlacer_core_tb: clean");
        else
            $display("line_doubling_deinterlacer_core_tb: errors");
        $finish;
    end

endmodule
